@@ src/aes_css_pkg.sv @@
package aes_css_pkg;

  localparam int IMM_W   = 64;
  localparam int IDX_W   = 16;
  localparam int ROW_LEN = 16;
  localparam int CONF_W  = 7;

  typedef enum logic [1:0] {
    OP_INSN = 2'd0,
    OP_IMM  = 2'd1,
    OP_EDGE = 2'd2,
    OP_END  = 2'd3
  } operation_t;

  typedef enum logic [2:0] {
    CLS_OTHER = 3'd0,
    CLS_XOR   = 3'd1,
    CLS_AND   = 3'd2,
    CLS_SHL   = 3'd3,
    CLS_SHR   = 3'd4,
    CLS_ADD   = 3'd5,
    CLS_CALL  = 3'd6
  } op_class_t;

  typedef enum logic [1:0] {
    MODE_ECB = 2'd0,
    MODE_CBC = 2'd1,
    MODE_CTR = 2'd2,
    MODE_GCM = 2'd3
  } mode_t;

  localparam logic [7:0] GF128_POLY_BYTE = 8'he1;
  localparam logic [7:0] AES_POLY_BYTE   = 8'h1b;

  localparam logic [7:0] W_SBOX      = 8'd30;
  localparam logic [7:0] W_RCON      = 8'd20;
  localparam logic [7:0] W_POLY      = 8'd5;
  localparam logic [7:0] W_ROUND     = 8'd25;
  localparam logic [7:0] W_INTRINSIC = 8'd20;
  localparam logic [7:0] CONF_MAX    = 8'd100;

  // Accumulated evidence for one function.
  typedef struct packed {
    logic [2:0] xor_count;
    logic [1:0] add_count;
    logic       has_and;
    logic       has_shl;
    logic       has_shr;
    logic       sbox_const;
    logic       rcon_const;
    logic       poly_const;
    logic       gf_const;
    logic       back_edge;
    logic       intrinsic;
    logic       run;
  } stats_t;

  typedef struct packed {
    logic              found;
    logic [CONF_W-1:0] confidence;
    mode_t             mode;
    logic              uses_aes;
    logic              sbox_run;
    logic              annotate;
  } result_t;

  // First row of the forward (inv = 0) or inverse (inv = 1) S-box.
  function automatic logic [7:0] row_byte(input logic inv, input logic [3:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (!inv) begin
      case (idx)
        4'd0:  b = 8'h63;
        4'd1:  b = 8'h7c;
        4'd2:  b = 8'h77;
        4'd3:  b = 8'h7b;
        4'd4:  b = 8'hf2;
        4'd5:  b = 8'h6b;
        4'd6:  b = 8'h6f;
        4'd7:  b = 8'hc5;
        4'd8:  b = 8'h30;
        4'd9:  b = 8'h01;
        4'd10: b = 8'h67;
        4'd11: b = 8'h2b;
        4'd12: b = 8'hfe;
        4'd13: b = 8'hd7;
        4'd14: b = 8'hab;
        default: b = 8'h76;
      endcase
    end else begin
      case (idx)
        4'd0:  b = 8'h52;
        4'd1:  b = 8'h09;
        4'd2:  b = 8'h6a;
        4'd3:  b = 8'hd5;
        4'd4:  b = 8'h30;
        4'd5:  b = 8'h36;
        4'd6:  b = 8'ha5;
        4'd7:  b = 8'h38;
        4'd8:  b = 8'hbf;
        4'd9:  b = 8'h40;
        4'd10: b = 8'ha3;
        4'd11: b = 8'h9e;
        4'd12: b = 8'h81;
        4'd13: b = 8'hf3;
        4'd14: b = 8'hd7;
        default: b = 8'hfb;
      endcase
    end
    return b;
  endfunction

  function automatic logic is_sbox_byte(input logic [IMM_W-1:0] v);
    logic hit;
    hit = 1'b0;
    case (v[7:0])
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b,
      8'h6f, 8'hc5, 8'h52, 8'h09, 8'h6a, 8'hd5: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit && (v[IMM_W-1:8] == '0);
  endfunction

  function automatic logic is_rcon_byte(input logic [IMM_W-1:0] v);
    logic hit;
    hit = 1'b0;
    case (v[7:0])
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
      8'h20, 8'h40, 8'h80, 8'h1b, 8'h36: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit && (v[IMM_W-1:8] == '0);
  endfunction

endpackage

@@ src/aes_css_row_tracker.sv @@
module aes_css_row_tracker #(
  parameter int MIN_RUN = 4,
  parameter bit INVERSE = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          clear,
  input  logic [aes_css_pkg::IMM_W-1:0] imm,
  output logic                          done
);

  localparam int NSTART = aes_css_pkg::ROW_LEN - MIN_RUN + 1;
  localparam int PW     = $clog2(MIN_RUN + 1);
  localparam logic [PW-1:0] RUN_LEN = PW'(MIN_RUN);

  logic [PW-1:0] prog_r   [NSTART];
  logic [PW-1:0] prog_nxt [NSTART];
  logic [NSTART-1:0] hit;

  for (genvar s = 0; s < NSTART; s++) begin : g_start
    logic [3:0] idx;
    logic [7:0] want;
    assign idx  = 4'(s) + 4'(prog_r[s]);
    assign want = aes_css_pkg::row_byte(INVERSE, idx);
    assign hit[s] = (prog_r[s] >= RUN_LEN);

    always_comb begin
      prog_nxt[s] = prog_r[s];
      if (clear) begin
        prog_nxt[s] = '0;
      end else if (step && !hit[s] && imm == {{(aes_css_pkg::IMM_W-8){1'b0}}, want}) begin
        prog_nxt[s] = prog_r[s] + PW'(1);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        prog_r[s] <= '0;
      end else begin
        prog_r[s] <= prog_nxt[s];
      end
    end
  end

  assign done = |hit;

endmodule

@@ src/aes_css_scorer.sv @@
module aes_css_scorer (
  input  aes_css_pkg::stats_t                   stats,
  input  logic [aes_css_pkg::CONF_W-1:0]        threshold,
  output aes_css_pkg::result_t                  result
);

  logic       found;
  logic       round;
  logic [7:0] sum;
  logic [aes_css_pkg::CONF_W-1:0] conf;
  aes_css_pkg::mode_t mode;

  always_comb begin
    found = stats.run || stats.intrinsic;
    round = (stats.xor_count >= 3'd4) && stats.has_and && (stats.has_shl || stats.has_shr);

    sum = (stats.sbox_const ? aes_css_pkg::W_SBOX : 8'd0)
        + (stats.rcon_const ? aes_css_pkg::W_RCON : 8'd0)
        + (stats.poly_const ? aes_css_pkg::W_POLY : 8'd0)
        + (round ? aes_css_pkg::W_ROUND : 8'd0)
        + (stats.intrinsic ? aes_css_pkg::W_INTRINSIC : 8'd0);
    if (!found) begin
      conf = '0;
    end else if (sum > aes_css_pkg::CONF_MAX) begin
      conf = aes_css_pkg::CONF_W'(aes_css_pkg::CONF_MAX);
    end else begin
      conf = sum[aes_css_pkg::CONF_W-1:0];
    end

    if (!found) begin
      mode = aes_css_pkg::MODE_ECB;
    end else if (stats.gf_const && stats.xor_count >= 3'd2 && stats.has_shl) begin
      mode = aes_css_pkg::MODE_GCM;
    end else if (stats.back_edge && stats.add_count >= 2'd2 && stats.xor_count != 3'd0) begin
      mode = aes_css_pkg::MODE_CTR;
    end else if (stats.xor_count != 3'd0) begin
      mode = aes_css_pkg::MODE_CBC;
    end else begin
      mode = aes_css_pkg::MODE_ECB;
    end

    result.found      = found;
    result.confidence = conf;
    result.mode       = mode;
    result.uses_aes   = found && stats.intrinsic;
    result.sbox_run   = found && stats.run;
    result.annotate   = found && (conf >= threshold);
  end

endmodule

@@ src/aes_code_signature_scanner_unit.sv @@
// An end-of-function request passes two register stages (request, result)
// before its result shows on out_valid.
// Throughput: one request per cycle; the result register frees the input
// side, and only an end-of-function request waits for a full result slot.
// Reset (rst_n low, synchronous): all evidence cleared, pipeline empty,
// annotate threshold back to 50.
module aes_code_signature_scanner_unit #(
  parameter int MIN_RUN          = 4,
  parameter int BLOCK_INDEX_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_operation,
  input  logic [2:0]                       in_op_class,
  input  logic                             in_callee_is_aes_intrinsic,
  input  logic [aes_css_pkg::IMM_W-1:0]    in_immediate_value,
  input  logic [aes_css_pkg::IDX_W-1:0]    in_block_index,
  input  logic [aes_css_pkg::IDX_W-1:0]    in_successor_index,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_found,
  output logic [aes_css_pkg::CONF_W-1:0]   out_confidence,
  output logic [1:0]                       out_mode,
  output logic                             out_uses_aes_instructions,
  output logic                             out_sbox_run_seen,
  output logic                             out_annotate,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [aes_css_pkg::CONF_W-1:0]   cfg_annotate_threshold
);

  // Only the low index bits take part in the back-edge compare.
  localparam int CMP_W = (BLOCK_INDEX_BITS < aes_css_pkg::IDX_W) ?
                         BLOCK_INDEX_BITS : aes_css_pkg::IDX_W;
  localparam logic [aes_css_pkg::CONF_W-1:0] THRESH_RST = 7'd50;

  // ---------------- request register ----------------
  logic                            s1_valid_r;
  aes_css_pkg::operation_t         s1_op_r;
  logic [2:0]                      s1_cls_r;
  logic                            s1_intr_r;
  logic [aes_css_pkg::IMM_W-1:0]   s1_imm_r;
  logic [CMP_W-1:0]                s1_blk_r;
  logic [CMP_W-1:0]                s1_succ_r;
  logic                            s1_adv;
  logic                            s1_is_end;

  // An end request needs the result slot free (or draining this cycle);
  // every other request retires into the evidence registers at once.
  assign s1_is_end = (s1_op_r == aes_css_pkg::OP_END);
  assign s1_adv    = s1_valid_r && (!s1_is_end || !out_valid || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Payload: no reset, load on accept.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r   <= aes_css_pkg::operation_t'(in_operation);
      s1_cls_r  <= in_op_class;
      s1_intr_r <= in_callee_is_aes_intrinsic;
      s1_imm_r  <= in_immediate_value;
      s1_blk_r  <= in_block_index[CMP_W-1:0];
      s1_succ_r <= in_successor_index[CMP_W-1:0];
    end
  end

  // ---------------- evidence registers ----------------
  logic [2:0] xor_cnt_r,   xor_cnt_nxt;
  logic [1:0] add_cnt_r,   add_cnt_nxt;
  logic [2:0] op_flags_r,  op_flags_nxt;    // and, shl, shr
  logic [3:0] cst_flags_r, cst_flags_nxt;   // sbox byte, rcon, 0x1b, 0xe1
  logic       back_edge_r, back_edge_nxt;
  logic       intr_r,      intr_nxt;

  logic imm_step;
  logic clear_all;
  logic fwd_done, inv_done;

  assign imm_step  = s1_adv && (s1_op_r == aes_css_pkg::OP_IMM);
  assign clear_all = s1_adv && s1_is_end;

  always_comb begin
    xor_cnt_nxt   = xor_cnt_r;
    add_cnt_nxt   = add_cnt_r;
    op_flags_nxt  = op_flags_r;
    cst_flags_nxt = cst_flags_r;
    back_edge_nxt = back_edge_r;
    intr_nxt      = intr_r;
    if (s1_adv) begin
      unique case (s1_op_r)
        aes_css_pkg::OP_INSN: begin
          case (s1_cls_r)
            aes_css_pkg::CLS_XOR:  if (xor_cnt_r != 3'd7) xor_cnt_nxt = xor_cnt_r + 3'd1;
            aes_css_pkg::CLS_AND:  op_flags_nxt[0] = 1'b1;
            aes_css_pkg::CLS_SHL:  op_flags_nxt[1] = 1'b1;
            aes_css_pkg::CLS_SHR:  op_flags_nxt[2] = 1'b1;
            aes_css_pkg::CLS_ADD:  if (add_cnt_r != 2'd3) add_cnt_nxt = add_cnt_r + 2'd1;
            aes_css_pkg::CLS_CALL: if (s1_intr_r) intr_nxt = 1'b1;
            default: ;  // other kinds, and the unused class code, leave no trace
          endcase
        end
        aes_css_pkg::OP_IMM: begin
          if (aes_css_pkg::is_sbox_byte(s1_imm_r)) cst_flags_nxt[0] = 1'b1;
          if (aes_css_pkg::is_rcon_byte(s1_imm_r)) cst_flags_nxt[1] = 1'b1;
          if (s1_imm_r == {{(aes_css_pkg::IMM_W-8){1'b0}}, aes_css_pkg::AES_POLY_BYTE})
            cst_flags_nxt[2] = 1'b1;
          if (s1_imm_r == {{(aes_css_pkg::IMM_W-8){1'b0}}, aes_css_pkg::GF128_POLY_BYTE})
            cst_flags_nxt[3] = 1'b1;
        end
        aes_css_pkg::OP_EDGE: begin
          // back edge: successor does not lie after its owner
          if (s1_succ_r <= s1_blk_r) back_edge_nxt = 1'b1;
        end
        aes_css_pkg::OP_END: begin
          // score is taken from the current values; drop everything after
          xor_cnt_nxt   = '0;
          add_cnt_nxt   = '0;
          op_flags_nxt  = '0;
          cst_flags_nxt = '0;
          back_edge_nxt = 1'b0;
          intr_nxt      = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_cnt_r   <= '0;
      add_cnt_r   <= '0;
      op_flags_r  <= '0;
      cst_flags_r <= '0;
      back_edge_r <= 1'b0;
      intr_r      <= 1'b0;
    end else begin
      xor_cnt_r   <= xor_cnt_nxt;
      add_cnt_r   <= add_cnt_nxt;
      op_flags_r  <= op_flags_nxt;
      cst_flags_r <= cst_flags_nxt;
      back_edge_r <= back_edge_nxt;
      intr_r      <= intr_nxt;
    end
  end

  // Ordered-run trackers for the forward and inverse S-box first rows.
  aes_css_row_tracker #(
    .MIN_RUN (MIN_RUN),
    .INVERSE (1'b0)
  ) u_fwd_row (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (imm_step),
    .clear (clear_all),
    .imm   (s1_imm_r),
    .done  (fwd_done)
  );

  aes_css_row_tracker #(
    .MIN_RUN (MIN_RUN),
    .INVERSE (1'b1)
  ) u_inv_row (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (imm_step),
    .clear (clear_all),
    .imm   (s1_imm_r),
    .done  (inv_done)
  );

  // ---------------- configuration ----------------
  logic [aes_css_pkg::CONF_W-1:0] thresh_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      thresh_r <= cfg_annotate_threshold;
    end
  end

  // ---------------- scoring and result register ----------------
  aes_css_pkg::stats_t  stats;
  aes_css_pkg::result_t result;
  aes_css_pkg::result_t res_r;
  logic                 out_valid_r;

  always_comb begin
    stats.xor_count  = xor_cnt_r;
    stats.add_count  = add_cnt_r;
    stats.has_and    = op_flags_r[0];
    stats.has_shl    = op_flags_r[1];
    stats.has_shr    = op_flags_r[2];
    stats.sbox_const = cst_flags_r[0];
    stats.rcon_const = cst_flags_r[1];
    stats.poly_const = cst_flags_r[2];
    stats.gf_const   = cst_flags_r[3];
    stats.back_edge  = back_edge_r;
    stats.intrinsic  = intr_r;
    stats.run        = fwd_done || inv_done;
  end

  aes_css_scorer u_scorer (
    .stats     (stats),
    .threshold (thresh_r),
    .result    (result)
  );

  // Hold the result until taken; load a new one when an end request retires.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (clear_all) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clear_all) begin
      res_r <= result;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_found                 = res_r.found;
  assign out_confidence            = res_r.confidence;
  assign out_mode                  = res_r.mode;
  assign out_uses_aes_instructions = res_r.uses_aes;
  assign out_sbox_run_seen         = res_r.sbox_run;
  assign out_annotate              = res_r.annotate;

endmodule
